// File: sv/swd_pkg.sv
// ---------------------------------------------------------------------------
// swd_pkg
// Shared types and codes for the session inactivity watchdog: request modes,
// event codes, register indexes and the configuration and result records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swd_pkg;

	// Field widths
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned MIN_W   = 10;
	localparam int unsigned SEC_W   = 10;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 10;
	localparam int unsigned ELAP_W  = 11;
	localparam int unsigned SIM_W   = 6;
	localparam int unsigned WARN_W  = 2;

	// Counter limits
	localparam logic [SIM_W:0]    SEC_PER_MIN  = 7'd60;
	localparam logic [ELAP_W-1:0] MAX_ELAPSED  = 11'd2047;
	localparam logic [SEC_W-1:0]  MAX_IDLE     = 10'd1023;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACTIVITY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START    = 2'd2;

	// Idle events
	localparam logic [EVENT_W-1:0] IDLE_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] IDLE_WARN2   = 3'd1;
	localparam logic [EVENT_W-1:0] IDLE_WARN1   = 3'd2;
	localparam logic [EVENT_W-1:0] IDLE_LOGOFF  = 3'd3;
	localparam logic [EVENT_W-1:0] IDLE_CARRIER = 3'd4;

	// Session events
	localparam logic [EVENT_W-1:0] SESS_NONE   = 3'd0;
	localparam logic [EVENT_W-1:0] SESS_LEFT5  = 3'd1;
	localparam logic [EVENT_W-1:0] SESS_LEFT2  = 3'd2;
	localparam logic [EVENT_W-1:0] SESS_LEFT1  = 3'd3;
	localparam logic [EVENT_W-1:0] SESS_LOGOFF = 3'd4;

	// Remaining-minute marks
	localparam logic [MIN_W-1:0] REM_FIVE = 10'd5;
	localparam logic [MIN_W-1:0] REM_TWO  = 10'd2;
	localparam logic [MIN_W-1:0] REM_ONE  = 10'd1;
	localparam logic [MIN_W-1:0] REM_ZERO = 10'd0;

	// Warning levels
	localparam logic [WARN_W-1:0] WARN_NONE = 2'd0;
	localparam logic [WARN_W-1:0] WARN_TWO  = 2'd2;
	localparam logic [WARN_W-1:0] WARN_ONE  = 2'd3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SESSION_MINUTES = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOCAL_MODE      = 3'd1;
	localparam logic [IDX_W-1:0] REG_CARRIER_CHECK   = 3'd2;
	localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_IDLE_WARN_ONE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_IDLE_WARN_TWO   = 3'd5;

	// Register reset values
	localparam logic [MIN_W-1:0] RST_SESSION_MINUTES = 10'd60;
	localparam logic [SEC_W-1:0] RST_IDLE_TIMEOUT    = 10'd240;
	localparam logic [SEC_W-1:0] RST_IDLE_WARN_ONE   = 10'd180;
	localparam logic [SEC_W-1:0] RST_IDLE_WARN_TWO   = 10'd120;

	typedef struct packed {
		logic [MIN_W-1:0] session_minutes;
		logic             local_mode;
		logic             carrier_check_enable;
		logic [SEC_W-1:0] idle_timeout_seconds;
		logic [SEC_W-1:0] idle_warn_one_seconds;
		logic [SEC_W-1:0] idle_warn_two_seconds;
	} cfg_t;

	typedef struct packed {
		logic [EVENT_W-1:0] idle_event;
		logic [EVENT_W-1:0] session_event;
		logic [MIN_W-1:0]   remaining_minutes;
		logic               logoff;
	} res_t;

endpackage

`default_nettype wire

// File: sv/swd_if.sv
// ---------------------------------------------------------------------------
// swd_if
// Valid/ready channels of the watchdog: request, result and register write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swd_req_if;
	logic                      valid;
	logic                      ready;
	logic [swd_pkg::MODE_W-1:0] mode;
	logic                      carrier_present;

	modport source (output valid, mode, carrier_present, input ready);
	modport sink   (input valid, mode, carrier_present, output ready);
endinterface

interface swd_res_if;
	logic                        valid;
	logic                        ready;
	logic [swd_pkg::EVENT_W-1:0] idle_event;
	logic [swd_pkg::EVENT_W-1:0] session_event;
	logic [swd_pkg::MIN_W-1:0]   remaining_minutes;
	logic                        logoff;

	modport source (output valid, idle_event, session_event, remaining_minutes, logoff,
		input ready);
	modport sink   (input valid, idle_event, session_event, remaining_minutes, logoff,
		output ready);
endinterface

interface swd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [swd_pkg::IDX_W-1:0]  index;
	logic [swd_pkg::DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/swd_cfg_regs.sv
// ---------------------------------------------------------------------------
// swd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swd_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	swd_cfg_if.sink            cfg,
	output swd_pkg::cfg_t      regs
);

	swd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Update the addressed register on each write request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.session_minutes       <= swd_pkg::RST_SESSION_MINUTES;
			regs_q.local_mode            <= 1'b0;
			regs_q.carrier_check_enable  <= 1'b1;
			regs_q.idle_timeout_seconds  <= swd_pkg::RST_IDLE_TIMEOUT;
			regs_q.idle_warn_one_seconds <= swd_pkg::RST_IDLE_WARN_ONE;
			regs_q.idle_warn_two_seconds <= swd_pkg::RST_IDLE_WARN_TWO;
		end else if (cfg.valid) begin
			case (cfg.index)
				swd_pkg::REG_SESSION_MINUTES: regs_q.session_minutes <= cfg.data;
				swd_pkg::REG_LOCAL_MODE:      regs_q.local_mode <= cfg.data[0];
				swd_pkg::REG_CARRIER_CHECK:   regs_q.carrier_check_enable <= cfg.data[0];
				swd_pkg::REG_IDLE_TIMEOUT:    regs_q.idle_timeout_seconds <= cfg.data;
				swd_pkg::REG_IDLE_WARN_ONE:   regs_q.idle_warn_one_seconds <= cfg.data;
				swd_pkg::REG_IDLE_WARN_TWO:   regs_q.idle_warn_two_seconds <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/swd_core.sv
// ---------------------------------------------------------------------------
// swd_core
// Session and idle counters with the per-request checks; produces one result
// per request and commits the new state when the step is enabled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swd_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step_en,
	input  wire logic [swd_pkg::MODE_W-1:0] mode,
	input  wire logic                      carrier_present,
	input  swd_pkg::cfg_t                  regs,
	output swd_pkg::res_t                  result
);

	logic [swd_pkg::SIM_W-1:0]  sec_q, sec_n, sec_t;
	logic [swd_pkg::ELAP_W-1:0] elapsed_q, elapsed_n, elapsed_t;
	logic [swd_pkg::ELAP_W-1:0] last_q, last_n;
	logic [swd_pkg::SEC_W-1:0]  idle_q, idle_n, idle_t;
	logic                       seen_q, seen_n;
	logic [swd_pkg::WARN_W-1:0] warn_q, warn_n;
	logic                       logoff_q, logoff_n;
	logic [swd_pkg::SIM_W:0]    sec_inc;
	logic                       sec_wrap;
	logic                       active;
	logic [swd_pkg::MIN_W-1:0]  rem_t, rem_n;
	logic [swd_pkg::EVENT_W-1:0] idle_ev, sess_ev;

	// Remaining minutes, floored at zero
	function automatic logic [swd_pkg::MIN_W-1:0] minutes_left(
		input logic [swd_pkg::MIN_W-1:0]  allowed,
		input logic [swd_pkg::ELAP_W-1:0] elapsed
	);
		logic [swd_pkg::MIN_W-1:0] diff;
		diff = allowed - elapsed[swd_pkg::MIN_W-1:0];
		if (elapsed >= {1'b0, allowed})
			return swd_pkg::REM_ZERO;
		return diff;
	endfunction

	assign active = !regs.local_mode;

	// Advance the second, minute and idle counters for a tick
	assign sec_inc   = {1'b0, sec_q} + 7'd1;
	assign sec_wrap  = (sec_inc >= swd_pkg::SEC_PER_MIN);
	assign sec_t     = sec_wrap ? '0 : sec_inc[swd_pkg::SIM_W-1:0];
	assign elapsed_t = (sec_wrap && elapsed_q != swd_pkg::MAX_ELAPSED) ?
		elapsed_q + 11'd1 : elapsed_q;
	assign idle_t    = (idle_q != swd_pkg::MAX_IDLE) ? idle_q + 10'd1 : idle_q;
	assign rem_t     = minutes_left(regs.session_minutes, elapsed_t);

	// Work out the next state and the events of this request
	always_comb begin
		sec_n     = sec_q;
		elapsed_n = elapsed_q;
		last_n    = last_q;
		idle_n    = idle_q;
		seen_n    = seen_q;
		warn_n    = warn_q;
		logoff_n  = logoff_q;
		idle_ev   = swd_pkg::IDLE_NONE;
		sess_ev   = swd_pkg::SESS_NONE;
		case (mode)
			swd_pkg::MODE_START: begin
				sec_n     = '0;
				elapsed_n = '0;
				last_n    = '0;
				idle_n    = '0;
				seen_n    = 1'b0;
				warn_n    = swd_pkg::WARN_NONE;
				logoff_n  = 1'b0;
			end
			swd_pkg::MODE_ACTIVITY: begin
				idle_n = '0;
				warn_n = swd_pkg::WARN_NONE;
				seen_n = 1'b1;
			end
			swd_pkg::MODE_TICK: begin
				sec_n     = sec_t;
				elapsed_n = elapsed_t;
				idle_n    = idle_t;
				if (active && regs.carrier_check_enable && !carrier_present) begin
					idle_ev  = swd_pkg::IDLE_CARRIER;
					logoff_n = 1'b1;
				end else if (active && seen_q && idle_t >= regs.idle_timeout_seconds) begin
					idle_ev  = swd_pkg::IDLE_LOGOFF;
					logoff_n = 1'b1;
				end else begin
					// Idle warnings, each once per activity period
					if (active && seen_q) begin
						if (idle_t >= regs.idle_warn_one_seconds) begin
							if (warn_q < swd_pkg::WARN_ONE) begin
								warn_n  = swd_pkg::WARN_ONE;
								idle_ev = swd_pkg::IDLE_WARN1;
							end
						end else if (idle_t >= regs.idle_warn_two_seconds) begin
							if (warn_q < swd_pkg::WARN_TWO) begin
								warn_n  = swd_pkg::WARN_TWO;
								idle_ev = swd_pkg::IDLE_WARN2;
							end
						end
					end
					// Remaining-time report at each new minute
					if (elapsed_t > last_q) begin
						last_n = elapsed_t;
						if (active) begin
							if (rem_t == swd_pkg::REM_FIVE)
								sess_ev = swd_pkg::SESS_LEFT5;
							else if (rem_t == swd_pkg::REM_TWO)
								sess_ev = swd_pkg::SESS_LEFT2;
							else if (rem_t == swd_pkg::REM_ONE)
								sess_ev = swd_pkg::SESS_LEFT1;
							else if (rem_t == swd_pkg::REM_ZERO) begin
								sess_ev  = swd_pkg::SESS_LOGOFF;
								logoff_n = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign rem_n = minutes_left(regs.session_minutes, elapsed_n);

	assign result.idle_event        = idle_ev;
	assign result.session_event     = sess_ev;
	assign result.remaining_minutes = rem_n;
	assign result.logoff            = logoff_n;

	// Commit the state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= '0;
			elapsed_q <= '0;
			last_q    <= '0;
			idle_q    <= '0;
			seen_q    <= 1'b0;
			warn_q    <= swd_pkg::WARN_NONE;
			logoff_q  <= 1'b0;
		end else if (step_en) begin
			sec_q     <= sec_n;
			elapsed_q <= elapsed_n;
			last_q    <= last_n;
			idle_q    <= idle_n;
			seen_q    <= seen_n;
			warn_q    <= warn_n;
			logoff_q  <= logoff_n;
		end
	end

endmodule

`default_nettype wire

// File: sv/session_inactivity_watchdog_top.sv
// Requests are held in the input register; results go to the result register.
// Throughput: one request per cycle; the input register, the state update and
// the result register all advance together whenever the result slot is free.
// Reset: asynchronous, active low; clears all session state and loads the
// register defaults (60 minutes, carrier check on, idle limits 240/180/120 s).
// ---------------------------------------------------------------------------
// session_inactivity_watchdog_top
// Session inactivity watchdog: session clock, idle clock, idle warnings and
// timeouts, carrier loss and time-limit logoff, one result per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module session_inactivity_watchdog_top (
	input  wire logic clk,
	input  wire logic arst_n,
	swd_cfg_if.sink   cfg,
	swd_req_if.sink   req,
	swd_res_if.source res
);

	swd_pkg::cfg_t              regs;
	swd_pkg::res_t              core_res;
	swd_pkg::res_t              res_s2;
	logic                       valid_s1, valid_s2;
	logic [swd_pkg::MODE_W-1:0] mode_s1;
	logic                       carrier_s1;
	logic                       advance;
	logic                       step_en;

	swd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	swd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.mode            (mode_s1),
		.carrier_present (carrier_s1),
		.regs            (regs),
		.result          (core_res)
	);

	// Whole pipe moves when the result slot is empty or being taken
	assign advance   = !valid_s2 || res.ready;
	assign step_en   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// Hold the request and result payloads
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1    <= req.mode;
			carrier_s1 <= req.carrier_present;
		end
		if (step_en)
			res_s2 <= core_res;
	end

	assign res.valid             = valid_s2;
	assign res.idle_event        = res_s2.idle_event;
	assign res.session_event     = res_s2.session_event;
	assign res.remaining_minutes = res_s2.remaining_minutes;
	assign res.logoff            = res_s2.logoff;

`ifndef SYNTH
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && mode_s1 == swd_pkg::MODE_START) |=>
		(res.valid && !res.logoff && res.idle_event == swd_pkg::IDLE_NONE &&
		 res.session_event == swd_pkg::SESS_NONE))
		else $error("session start left logoff or an event set");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res.ready) |-> !step_en)
		else $error("result register overwritten while stalled");

	a_idle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.idle_event <= swd_pkg::IDLE_CARRIER &&
		res.session_event <= swd_pkg::SESS_LOGOFF))
		else $error("event code out of range");

	a_logoff_event: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.idle_event == swd_pkg::IDLE_LOGOFF ||
		res.idle_event == swd_pkg::IDLE_CARRIER ||
		res.session_event == swd_pkg::SESS_LOGOFF)) |-> res.logoff)
		else $error("logoff event without logoff flag");
`endif

endmodule

`default_nettype wire
